// ===== sv/adpcmd_pkg.sv =====
// Shared constants, types and helpers for the ADPCM nibble-pair decoder.
// Self-contained; used by adpcm_nibble_to_pcm8_decoder.
package adpcmd_pkg;

  localparam int SampleW = 16;
  localparam int StepW   = 15;
  localparam int CodeW   = 8;
  localparam int PcmW    = 8;
  localparam int CoefW   = 8;
  localparam int ProdW   = StepW + CoefW;
  localparam int CfgIdxW = 2;
  localparam int CfgDataW = 16;

  localparam logic [CfgIdxW-1:0] RegInitialSample = 2'd0;
  localparam logic [CfgIdxW-1:0] RegInitialStep   = 2'd1;

  localparam logic [StepW-1:0] StepMin = 15'd127;
  localparam logic [StepW-1:0] StepMax = 15'd24576;

  localparam logic signed [17:0] SampleMin = -18'sd32768;
  localparam logic signed [17:0] SampleMax = 18'sd32767;

  typedef logic [StepW-1:0]          step_t;
  typedef logic signed [SampleW-1:0] sample_t;
  typedef logic [PcmW-1:0]           pcm_t;

  function automatic logic [CoefW-1:0] step_factor(input logic [2:0] mag);
    logic [CoefW-1:0] f;
    case (mag)
      3'd4:    f = 8'd77;
      3'd5:    f = 8'd102;
      3'd6:    f = 8'd128;
      3'd7:    f = 8'd153;
      default: f = 8'd57;
    endcase
    return f;
  endfunction

  function automatic step_t clamp_step(input logic [15:0] v);
    step_t s;
    if (v < {1'b0, StepMin}) begin
      s = StepMin;
    end else if (v > {1'b0, StepMax}) begin
      s = StepMax;
    end else begin
      s = v[StepW-1:0];
    end
    return s;
  endfunction

  // predictor / 256 truncated toward zero, offset by 128
  function automatic pcm_t to_pcm(input sample_t p);
    logic signed [16:0] biased;
    logic signed [16:0] q;
    biased = p[15] ? (17'(p) + 17'sd255) : 17'(p);
    q = biased >>> 8;
    return q[7:0] ^ 8'h80;
  endfunction

endpackage

// ===== sv/adpcm_nibble_to_pcm8_decoder.sv =====
// ADPCM-B style decoder: one code byte in, two 8-bit PCM samples out.
// Depends on adpcmd_pkg for constants, the step factor table and PCM scaling.
//
// Usage:
//   Input channel (in_valid / in_stall) carries code_byte and first_of_sample.
//   A set first_of_sample reloads the predictor and step from the
//   initial_sample and initial_step registers (step clamped to 127..24576)
//   before the byte is decoded. The high nibble is decoded first.
//   Output channel (out_valid / out_stall) carries pcm_first and pcm_second,
//   one transfer per input byte.
//   Configuration: cfg_we writes cfg_data into register cfg_index
//   (0 initial_sample, 1 initial_step, others ignored); write only while idle.
// Timing:
//   One shared 15x8 multiplier runs four passes per byte (delta and step
//   update for each nibble), followed by the DONE state, which loads the
//   output register. No new byte is taken while the passes run.
//   A new byte is taken in the same cycle a finished result moves into the
//   output register, provided the previous result leaves at that edge.
// Reset: predictor 0, step 127, registers 0 and 127, no output pending.
// While out_stall holds a result, the next byte finishes its arithmetic and
// waits; in_stall stays high until the output register frees up.
module adpcm_nibble_to_pcm8_decoder (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [adpcmd_pkg::CfgIdxW-1:0]   cfg_index,
  input  logic [adpcmd_pkg::CfgDataW-1:0]  cfg_data,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [adpcmd_pkg::CodeW-1:0]     code_byte,
  input  logic                             first_of_sample,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [adpcmd_pkg::PcmW-1:0]      pcm_first,
  output logic [adpcmd_pkg::PcmW-1:0]      pcm_second
);
  import adpcmd_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_D1   = 3'd1;
  localparam logic [2:0] S_S1   = 3'd2;
  localparam logic [2:0] S_D2   = 3'd3;
  localparam logic [2:0] S_S2   = 3'd4;
  localparam logic [2:0] S_DONE = 3'd5;

  logic [2:0]       state;
  sample_t          initial_sample;
  logic [StepW-1:0] initial_step;
  sample_t          predictor;
  step_t            step_size;
  logic [CodeW-1:0] code;
  pcm_t             pcm_hi;
  pcm_t             pcm_lo;

  logic             out_free;
  logic             in_take;
  logic [3:0]       nibble;
  logic             delta_pass;
  logic [CoefW-1:0] coef;
  logic [ProdW-1:0] prod;
  logic signed [17:0] delta;
  logic signed [17:0] sum;
  sample_t          predictor_next;
  step_t            step_next;

  assign out_free = !out_valid || !out_stall;
  assign in_stall = !((state == S_IDLE) || ((state == S_DONE) && out_free));
  assign in_take  = in_valid && !in_stall;

  always_comb begin
    nibble     = ((state == S_D1) || (state == S_S1)) ? code[7:4] : code[3:0];
    delta_pass = (state == S_D1) || (state == S_D2);
    coef       = delta_pass ? {4'd0, nibble[2:0], 1'b1} : step_factor(nibble[2:0]);
    prod       = ProdW'(step_size) * ProdW'(coef);
    delta      = nibble[3] ? -18'(prod[18:3]) : 18'(prod[18:3]);
    sum        = 18'(predictor) + delta;
    if (sum < SampleMin) begin
      predictor_next = SampleMin[15:0];
    end else if (sum > SampleMax) begin
      predictor_next = SampleMax[15:0];
    end else begin
      predictor_next = sum[15:0];
    end
    step_next = clamp_step(prod[21:6]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      initial_sample <= '0;
      initial_step   <= StepMin;
    end else if (cfg_we) begin
      case (cfg_index)
        RegInitialSample: initial_sample <= cfg_data;
        RegInitialStep:   initial_step   <= cfg_data[StepW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      predictor <= '0;
      step_size <= StepMin;
      out_valid <= 1'b0;
    end else begin
      if ((state == S_DONE) && out_free) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_take) begin
            state <= S_D1;
          end
        end
        S_D1: begin
          predictor <= predictor_next;
          pcm_hi    <= to_pcm(predictor_next);
          state     <= S_S1;
        end
        S_S1: begin
          step_size <= step_next;
          state     <= S_D2;
        end
        S_D2: begin
          predictor <= predictor_next;
          pcm_lo    <= to_pcm(predictor_next);
          state     <= S_S2;
        end
        S_S2: begin
          step_size <= step_next;
          state     <= S_DONE;
        end
        S_DONE: begin
          if (out_free) begin
            pcm_first  <= pcm_hi;
            pcm_second <= pcm_lo;
            state      <= in_take ? S_D1 : S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
      if (in_take) begin
        code <= code_byte;
        if (first_of_sample) begin
          predictor <= initial_sample;
          step_size <= clamp_step({1'b0, initial_step});
        end
      end
    end
  end

  a_step_range: assert property (@(posedge clk) disable iff (rst)
    (step_size >= StepMin) && (step_size <= StepMax))
    else $error("step size left its range");

  a_take_when_free: assert property (@(posedge clk) disable iff (rst)
    !in_stall |-> ((state == S_IDLE) || (state == S_DONE)))
    else $error("input taken while busy");

  a_take_starts: assert property (@(posedge clk) disable iff (rst)
    in_take |=> (state == S_D1))
    else $error("accepted byte did not start decoding");

  a_done_follows: assert property (@(posedge clk) disable iff (rst)
    (state == S_S2) |=> (state == S_DONE))
    else $error("second step update not followed by completion");

endmodule

// ===== bench/tb_adpcm_nibble_to_pcm8_decoder.sv =====
`timescale 1ns / 1ps
// Testbench for adpcm_nibble_to_pcm8_decoder: streams code bytes over the valid/stall
// channels, tracks predictor and step alongside the block, checks each PCM pair in order.
// Depends on adpcmd_pkg and the decoder RTL.
module tb_adpcm_nibble_to_pcm8_decoder;
  import adpcmd_pkg::*;

  localparam int CycleLimit = 400000;
  localparam int DrainCycles = 20;
  localparam int HoldCycles = 300;
  localparam int BytesPerPhase = 150;
  localparam int MaxPrinted = 40;
  localparam logic [CfgIdxW-1:0] RegSpare2 = 2'd2;
  localparam logic [CfgIdxW-1:0] RegSpare3 = 2'd3;

  typedef struct packed {
    pcm_t first;
    pcm_t second;
  } pcm_pair_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [CfgIdxW-1:0] cfg_index = '0;
  logic [CfgDataW-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [CodeW-1:0] code_byte = '0;
  logic first_of_sample = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  pcm_t pcm_first;
  pcm_t pcm_second;

  logic [SampleW-1:0] start_sample = '0;
  logic [StepW-1:0] start_step = StepMin;
  int predictor_now = 0;
  int step_now = 127;
  int step_gain [8] = '{57, 57, 57, 57, 77, 102, 128, 153};
  pcm_pair_t pcm_expected_q [$];

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_left = 0;
  bit hold_req = 1'b0;
  bit hold_ack = 1'b0;
  int errors = 0;
  int bytes_sent = 0;
  int starts_sent = 0;
  int pairs_checked = 0;
  int cfg_writes = 0;
  int cycle_count = 0;

  adpcm_nibble_to_pcm8_decoder dut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .code_byte(code_byte),
    .first_of_sample(first_of_sample),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .pcm_first(pcm_first),
    .pcm_second(pcm_second)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  function automatic int clamp_int(input int v, input int lo, input int hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic pcm_t advance_nibble(input logic [3:0] code);
    int mag;
    int mult;
    int level;
    mag = int'(code[2:0]);
    mult = 2 * mag + 1;
    if (code[3]) begin
      mult = -mult;
    end
    predictor_now = clamp_int(predictor_now + (mult * step_now) / 8, -32768, 32767);
    step_now = clamp_int((step_now * step_gain[mag]) / 64, int'(StepMin), int'(StepMax));
    level = predictor_now / 256 + 128;
    return level[7:0];
  endfunction

  function automatic void track_register(input logic [CfgIdxW-1:0] idx,
                                         input logic [CfgDataW-1:0] data);
    case (idx)
      RegInitialSample: start_sample = data;
      RegInitialStep: start_step = data[StepW-1:0];
      default: ;
    endcase
  endfunction

  function automatic void expect_pcm_pair(input logic [7:0] b, input logic first);
    pcm_pair_t e;
    if (first) begin
      predictor_now = int'($signed(start_sample));
      step_now = clamp_int(int'(start_step), int'(StepMin), int'(StepMax));
    end
    e.first = advance_nibble(b[7:4]);
    e.second = advance_nibble(b[3:0]);
    pcm_expected_q.push_back(e);
  endfunction

  task automatic report_mismatch(input string what);
    errors++;
    if (errors <= MaxPrinted) begin
      $display("mismatch at cycle %0d: %s", cycle_count, what);
    end
  endtask

  // Receiver side: random stall, or a long hold when requested.
  always @(posedge clk) begin
    if (hold_req != hold_ack) begin
      hold_ack <= hold_req;
      hold_left <= HoldCycles;
      out_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  always @(posedge clk) begin : check_pcm
    pcm_pair_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pcm_expected_q.size() == 0) begin
        report_mismatch($sformatf("unexpected transfer %h %h", pcm_first, pcm_second));
      end else begin
        want = pcm_expected_q.pop_front();
        pairs_checked++;
        if (pcm_first !== want.first) begin
          report_mismatch($sformatf("pcm_first %h, want %h", pcm_first, want.first));
        end
        if (pcm_second !== want.second) begin
          report_mismatch($sformatf("pcm_second %h, want %h", pcm_second, want.second));
        end
      end
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic first);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    code_byte <= b;
    first_of_sample <= first;
    @(posedge clk);
    while (in_stall) begin
      @(posedge clk);
    end
    expect_pcm_pair(b, first);
    bytes_sent++;
    if (first) begin
      starts_sent++;
    end
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pcm_expected_q.size() != 0) begin
      @(posedge clk);
    end
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    wait_idle();
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    track_register(idx, data);
    cfg_writes++;
  endtask

  task automatic test_reset_state();
    send_byte(8'h00, 1'b0);
    send_byte(8'h7F, 1'b0);
    send_byte(8'hF8, 1'b0);
    send_byte(8'h88, 1'b0);
  endtask

  task automatic test_register_extremes();
    wait_idle();
    write_reg(RegInitialSample, 16'h7FFF);
    write_reg(RegInitialStep, 16'd24576);
    send_byte(8'h77, 1'b1);
    send_byte(8'h00, 1'b0);
    write_reg(RegInitialSample, 16'h8000);
    write_reg(RegInitialStep, 16'hFFFF);
    send_byte(8'hFF, 1'b1);
    send_byte(8'hF8, 1'b0);
    write_reg(RegInitialStep, 16'd0);
    send_byte(8'h08, 1'b1);
    write_reg(RegInitialStep, 16'd126);
    send_byte(8'h80, 1'b1);
    write_reg(RegInitialStep, 16'd24577);
    send_byte(8'h70, 1'b1);
    write_reg(RegInitialStep, 16'd127);
    send_byte(8'h11, 1'b1);
    wait_idle();
    write_reg(RegSpare2, 16'h1234);
    write_reg(RegSpare3, 16'hFFFF);
    send_byte(8'h42, 1'b1);
  endtask

  task automatic test_every_code();
    logic [7:0] b;
    wait_idle();
    write_reg(RegInitialSample, 16'h0000);
    write_reg(RegInitialStep, 16'd1000);
    for (int i = 0; i < 8; i++) begin
      b = {4'(2 * i), 4'(2 * i + 1)};
      send_byte(b, i == 0);
    end
  endtask

  task automatic test_random_phase(input int sender_pct, input int receiver_pct);
    logic [CfgDataW-1:0] step_word;
    wait_idle();
    send_idle_pct = sender_pct;
    recv_stall_pct = receiver_pct;
    if ($urandom_range(3) == 0) begin
      step_word = 16'($urandom);
    end else begin
      step_word = 16'($urandom_range(24576, 127));
    end
    write_reg(RegInitialSample, 16'($urandom));
    write_reg(RegInitialStep, step_word);
    for (int i = 0; i < BytesPerPhase; i++) begin
      send_byte(8'($urandom_range(255)), i == 0 || $urandom_range(19) == 0);
    end
  endtask

  task automatic test_backpressure();
    wait_idle();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    write_reg(RegInitialSample, 16'($urandom));
    write_reg(RegInitialStep, 16'($urandom_range(24576, 127)));
    hold_req = ~hold_req;
    for (int i = 0; i < 24; i++) begin
      send_byte(8'($urandom_range(255)), i == 0);
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_state();
    test_register_extremes();
    test_every_code();
    test_random_phase(0, 0);
    test_random_phase(50, 0);
    test_random_phase(0, 50);
    test_random_phase(35, 35);
    test_backpressure();
    wait_idle();
    $display("decoded %0d code bytes across %0d sample starts, %0d pcm pairs checked",
             bytes_sent, starts_sent, pairs_checked);
    $display("%0d register writes; sender/receiver idling mixes and a %0d-cycle output hold",
             cfg_writes, HoldCycles);
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("%0d mismatches", errors);
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
